// ----- rtl/src_pkg.sv -----
// Package: shared widths, codes and constants for the strobe rate controller.
`timescale 1ns / 1ps
`default_nettype none

package src_pkg;

    localparam int SPEED_BITS   = 24;
    localparam int ON_TIME_BITS = 26;
    localparam int PHASE_BITS   = 30;
    localparam int CNT_BITS     = 20;
    localparam int RATIO_BITS   = 4;
    localparam int STEP_BITS    = 3;
    localparam int OP_BITS      = 2;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 20;
    localparam int STEP_VAL_BITS = 13;

    localparam logic [ON_TIME_BITS-1:0] MINUTE_US = ON_TIME_BITS'(60000000);
    localparam logic [SPEED_BITS-1:0]   SPEED_MAX = {SPEED_BITS{1'b1}};
    localparam logic [SPEED_BITS-1:0]   SPEED_FLOOR = SPEED_BITS'(10);
    localparam logic [SPEED_BITS-1:0]   SPEED_FORCED = SPEED_BITS'(1);
    localparam logic [PHASE_BITS-1:0]   PHASE_MAX = {PHASE_BITS{1'b1}};
    localparam logic [CNT_BITS-1:0]     CNT_MAX = {CNT_BITS{1'b1}};

    localparam logic [CNT_BITS-1:0]   HOLD_LIMIT_RST   = CNT_BITS'(60000);
    localparam logic [CNT_BITS-1:0]   LOCKOUT_RST      = CNT_BITS'(250000);
    localparam logic [RATIO_BITS-1:0] RATIO_RST        = RATIO_BITS'(9);
    localparam logic [STEP_BITS-1:0]  STEP_RST         = STEP_BITS'(3);
    localparam logic [STEP_BITS-1:0]  STEP_FIRST       = STEP_BITS'(1);
    localparam logic [STEP_BITS-1:0]  STEP_LAST        = STEP_BITS'(5);

    localparam logic [OP_BITS-1:0] OP_TICK    = 2'd0;
    localparam logic [OP_BITS-1:0] OP_ENCODER = 2'd1;
    localparam logic [OP_BITS-1:0] OP_BUTTON  = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_HOLD_LIMIT = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LOCKOUT    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RATIO      = 2'd2;

    // step size for a step index; index wraps modulo five after subtracting one
    function automatic logic [STEP_VAL_BITS-1:0] step_size(input logic [STEP_BITS-1:0] idx);
        logic [STEP_VAL_BITS-1:0] val;
        unique case (idx)
            3'd1, 3'd6: val = STEP_VAL_BITS'(1);
            3'd2, 3'd7: val = STEP_VAL_BITS'(5);
            3'd3:       val = STEP_VAL_BITS'(50);
            3'd4:       val = STEP_VAL_BITS'(500);
            default:    val = STEP_VAL_BITS'(5000);
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/src_in_if.sv -----
// Interface: input item channel.
`timescale 1ns / 1ps
`default_nettype none

interface src_in_if
    import src_pkg::*;
    ();
    logic               valid;
    logic               ready;
    logic [OP_BITS-1:0] operation;
    logic               encoder_a;
    logic               encoder_b;
    logic               button_level;

    modport source (output valid, operation, encoder_a, encoder_b, button_level,
                    input ready);
    modport sink   (input valid, operation, encoder_a, encoder_b, button_level,
                    output ready);
endinterface

`default_nettype wire

// ----- rtl/src_out_if.sv -----
// Interface: result item channel.
`timescale 1ns / 1ps
`default_nettype none

interface src_out_if
    import src_pkg::*;
    ();
    logic                    valid;
    logic                    ready;
    logic                    led_on;
    logic [SPEED_BITS-1:0]   speed_value;
    logic [STEP_BITS-1:0]    step_select;
    logic [ON_TIME_BITS-1:0] on_time_us;
    logic                    press_event;

    modport source (output valid, led_on, speed_value, step_select, on_time_us,
                    press_event, input ready);
    modport sink   (input valid, led_on, speed_value, step_select, on_time_us,
                    press_event, output ready);
endinterface

`default_nettype wire

// ----- rtl/src_cfg_if.sv -----
// Interface: configuration write channel.
`timescale 1ns / 1ps
`default_nettype none

interface src_cfg_if
    import src_pkg::*;
    ();
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/src_divider.sv -----
// Restoring divider: one quotient bit per cycle of the minute constant by the speed.
`timescale 1ns / 1ps
`default_nettype none

module src_divider
    import src_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic [SPEED_BITS-1:0]   divisor,
    output logic                         done,
    output logic [ON_TIME_BITS-1:0]      quotient
);

    localparam int CNT_W = $clog2(ON_TIME_BITS);

    logic                    busy_reg;
    logic                    done_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [SPEED_BITS-1:0]   rem_reg;
    logic [SPEED_BITS-1:0]   div_reg;
    logic [ON_TIME_BITS-1:0] quot_reg;

    logic [SPEED_BITS:0]     trial;
    logic [SPEED_BITS:0]     diff;
    logic                    fits;

    always_comb
    begin
        trial = {rem_reg, MINUTE_US[cnt_reg]};
        diff  = trial - {1'b0, div_reg};
        fits  = trial >= {1'b0, div_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            div_reg  <= '0;
            quot_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(ON_TIME_BITS - 1);
                rem_reg  <= '0;
                div_reg  <= divisor;
            end
            else if (busy_reg)
            begin
                rem_reg  <= fits ? diff[SPEED_BITS-1:0] : trial[SPEED_BITS-1:0];
                quot_reg <= {quot_reg[ON_TIME_BITS-2:0], fits};
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

`default_nettype wire

// ----- rtl/strobe_rate_controller_core.sv -----
// Top level: strobe timing controller with sequencer and one divider.
//
//   channel  | dir  | handshake     | word
//   ---------+------+---------------+---------------------------------------------
//   item     | in   | valid/ready   | operation, encoder_a, encoder_b, button_level
//   result   | out  | valid/ready   | led_on, speed_value, step_select, on_time_us,
//            |      |               | press_event
//   cfg      | in   | valid/ready   | index, data (always ready)
//
// Tick steps: multiply, compare, deliver. Button sample and idle code go straight to deliver.
// Encoder edge: waits in the divide state for the 26-step divider, then delivers.
// A finished result waits in the output register while the next word is taken.
// Reset restores the power-up state of all counters and registers; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module strobe_rate_controller_core
    import src_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    src_in_if.sink    item,
    src_out_if.source result,
    src_cfg_if.sink   cfg
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_TICK,
        S_DIV,
        S_DONE
    } state_t;

    state_t                  state_reg, state_next;
    logic [SPEED_BITS-1:0]   speed_reg, speed_next;
    logic [STEP_BITS-1:0]    step_reg, step_next;
    logic [ON_TIME_BITS-1:0] on_time_reg, on_time_next;
    logic                    led_reg, led_next;
    logic [PHASE_BITS-1:0]   phase_reg, phase_next;
    logic [CNT_BITS-1:0]     hold_reg, hold_next;
    logic [CNT_BITS-1:0]     lockout_reg, lockout_next;
    logic [PHASE_BITS-1:0]   off_len_reg, off_len_next;
    logic                    press_reg, press_next;
    logic [CNT_BITS-1:0]     hold_limit_reg;
    logic [CNT_BITS-1:0]     lockout_limit_reg;
    logic [RATIO_BITS-1:0]   ratio_reg;
    logic                    out_valid_reg, out_valid_next;
    logic                    out_led_reg, out_led_next;
    logic [SPEED_BITS-1:0]   out_speed_reg, out_speed_next;
    logic [STEP_BITS-1:0]    out_step_reg, out_step_next;
    logic [ON_TIME_BITS-1:0] out_on_reg, out_on_next;
    logic                    out_press_reg, out_press_next;

    logic                       accept;
    logic                       div_start;
    logic                       div_done;
    logic [ON_TIME_BITS-1:0]    div_quot;
    logic [STEP_VAL_BITS-1:0]   step_val;
    logic signed [SPEED_BITS+1:0] sum;
    logic [CNT_BITS-1:0]        hold_inc;

    assign item.ready = (state_reg == S_IDLE);
    assign accept     = item.valid && item.ready;
    assign cfg.ready  = 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        speed_next     = speed_reg;
        step_next      = step_reg;
        on_time_next   = on_time_reg;
        led_next       = led_reg;
        phase_next     = phase_reg;
        hold_next      = hold_reg;
        lockout_next   = lockout_reg;
        off_len_next   = off_len_reg;
        press_next     = press_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_led_next   = out_led_reg;
        out_speed_next = out_speed_reg;
        out_step_next  = out_step_reg;
        out_on_next    = out_on_reg;
        out_press_next = out_press_reg;
        div_start      = 1'b0;

        step_val = step_size(step_reg);
        if (item.encoder_a ^ item.encoder_b)
            sum = $signed({2'b00, speed_reg}) + $signed((SPEED_BITS+2)'(step_val));
        else
            sum = $signed({2'b00, speed_reg}) - $signed((SPEED_BITS+2)'(step_val));
        hold_inc = (!item.button_level && hold_reg < CNT_MAX) ? hold_reg + 1'b1 : hold_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    press_next = 1'b0;
                    state_next = S_DONE;
                    if (item.operation == OP_TICK)
                    begin
                        if (lockout_reg < CNT_MAX)
                            lockout_next = lockout_reg + 1'b1;
                        if (phase_reg < PHASE_MAX)
                            phase_next = phase_reg + 1'b1;
                        off_len_next = PHASE_BITS'(ratio_reg) * PHASE_BITS'(on_time_reg);
                        state_next   = S_TICK;
                    end
                    else if (item.operation == OP_ENCODER)
                    begin
                        priority if (sum <= $signed((SPEED_BITS+2)'(1)))
                            speed_next = SPEED_FLOOR;
                        else if (sum > $signed({2'b00, SPEED_MAX}))
                            speed_next = SPEED_MAX;
                        else
                            speed_next = sum[SPEED_BITS-1:0];
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                    else if (item.operation == OP_BUTTON)
                    begin
                        hold_next = hold_inc;
                        priority if (hold_inc >= hold_limit_reg)
                        begin
                            speed_next = SPEED_FORCED;
                            hold_next  = '0;
                        end
                        else if (hold_inc != '0 && item.button_level)
                        begin
                            press_next = 1'b1;
                            hold_next  = '0;
                            if (lockout_reg >= lockout_limit_reg)
                            begin
                                step_next    = (step_reg == STEP_LAST) ? STEP_FIRST
                                                                       : step_reg + 1'b1;
                                lockout_next = '0;
                            end
                        end
                        else
                        begin
                            press_next = 1'b0;
                        end
                    end
                end
            end
            S_TICK:
            begin
                if (!led_reg)
                begin
                    if (phase_reg >= off_len_reg)
                    begin
                        led_next   = 1'b1;
                        phase_next = '0;
                    end
                end
                else if (phase_reg >= PHASE_BITS'(on_time_reg))
                begin
                    led_next   = 1'b0;
                    phase_next = '0;
                end
                state_next = S_DONE;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    on_time_next = div_quot;
                    state_next   = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_led_next   = led_reg;
                    out_speed_next = speed_reg;
                    out_step_next  = step_reg;
                    out_on_next    = on_time_reg;
                    out_press_next = press_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            speed_reg         <= '0;
            step_reg          <= STEP_RST;
            on_time_reg       <= '0;
            led_reg           <= 1'b0;
            phase_reg         <= '0;
            hold_reg          <= '0;
            lockout_reg       <= '0;
            off_len_reg       <= '0;
            press_reg         <= 1'b0;
            hold_limit_reg    <= HOLD_LIMIT_RST;
            lockout_limit_reg <= LOCKOUT_RST;
            ratio_reg         <= RATIO_RST;
            out_valid_reg     <= 1'b0;
            out_led_reg       <= 1'b0;
            out_speed_reg     <= '0;
            out_step_reg      <= '0;
            out_on_reg        <= '0;
            out_press_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            speed_reg     <= speed_next;
            step_reg      <= step_next;
            on_time_reg   <= on_time_next;
            led_reg       <= led_next;
            phase_reg     <= phase_next;
            hold_reg      <= hold_next;
            lockout_reg   <= lockout_next;
            off_len_reg   <= off_len_next;
            press_reg     <= press_next;
            out_valid_reg <= out_valid_next;
            out_led_reg   <= out_led_next;
            out_speed_reg <= out_speed_next;
            out_step_reg  <= out_step_next;
            out_on_reg    <= out_on_next;
            out_press_reg <= out_press_next;
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    CFG_HOLD_LIMIT: hold_limit_reg    <= cfg.data[CNT_BITS-1:0];
                    CFG_LOCKOUT:    lockout_limit_reg <= cfg.data[CNT_BITS-1:0];
                    CFG_RATIO:      ratio_reg         <= cfg.data[RATIO_BITS-1:0];
                    default:        ;
                endcase
            end
        end
    end

    src_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (speed_next),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign result.valid       = out_valid_reg;
    assign result.led_on      = out_led_reg;
    assign result.speed_value = out_speed_reg;
    assign result.step_select = out_step_reg;
    assign result.on_time_us  = out_on_reg;
    assign result.press_event = out_press_reg;

`ifndef NO_ASSERTIONS
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside divide state");

    a_enc_enters_div: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.operation == OP_ENCODER) |=> state_reg == S_DIV)
        else $error("encoder word did not start the divider");

    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> speed_reg != '0)
        else $error("divide by zero speed");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg >= STEP_FIRST && step_reg <= STEP_LAST)
        else $error("step index out of range");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_valid_reg && !result.ready) |=> state_reg == S_DONE)
        else $error("result dropped while output stalled");
`endif

endmodule

`default_nettype wire

// ----- bench/strobe_rate_checker.sv -----
// Checker: predicts every strobe controller result word and compares it with the block.
`timescale 1ns / 1ps

module strobe_rate_checker
    import src_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    src_in_if         item,
    src_out_if        result,
    src_cfg_if        cfg,
    output int        fail_count,
    output int        pending
);

    typedef struct packed {
        logic                    led_on;
        logic [SPEED_BITS-1:0]   speed_value;
        logic [STEP_BITS-1:0]    step_select;
        logic [ON_TIME_BITS-1:0] on_time_us;
        logic                    press_event;
    } strobe_word_t;

    logic [CNT_BITS-1:0]     hold_limit_cfg;
    logic [CNT_BITS-1:0]     lockout_cfg;
    logic [RATIO_BITS-1:0]   ratio_cfg;

    logic [SPEED_BITS-1:0]   speed_q;
    logic [STEP_BITS-1:0]    step_q;
    logic [ON_TIME_BITS-1:0] on_time_q;
    logic                    led_q;
    logic [PHASE_BITS-1:0]   phase_q;
    logic [CNT_BITS-1:0]     hold_q;
    logic [CNT_BITS-1:0]     lockout_q;

    strobe_word_t            strobe_words[$];
    int                      mismatches;

    function automatic longint step_amount(input logic [STEP_BITS-1:0] sel);
        case (sel)
            3'd1:    return 1;
            3'd2:    return 5;
            3'd3:    return 50;
            3'd4:    return 500;
            default: return 5000;
        endcase
    endfunction

    task automatic apply_register(input logic [CFG_IDX_BITS-1:0] idx,
                                  input logic [CFG_DATA_BITS-1:0] data);
        case (idx)
            CFG_HOLD_LIMIT: hold_limit_cfg = data;
            CFG_LOCKOUT:    lockout_cfg = data;
            CFG_RATIO:      ratio_cfg = data[RATIO_BITS-1:0];
            default:        ;
        endcase
    endtask

    task automatic predict_word(input logic [OP_BITS-1:0] op, input logic a, input logic b,
                                input logic btn, output strobe_word_t w);
        logic [PHASE_BITS:0] off_len;
        longint              step_val;
        longint              next_speed;
        logic                pressed;
        pressed = 1'b0;
        case (op)
            OP_TICK:
            begin
                if (lockout_q < CNT_MAX) lockout_q = lockout_q + 1'b1;
                if (phase_q < PHASE_MAX) phase_q = phase_q + 1'b1;
                off_len = (PHASE_BITS+1)'(ratio_cfg) * (PHASE_BITS+1)'(on_time_q);
                if (!led_q)
                begin
                    if ({1'b0, phase_q} >= off_len)
                    begin
                        led_q = 1'b1;
                        phase_q = '0;
                    end
                end
                else if (phase_q >= PHASE_BITS'(on_time_q))
                begin
                    led_q = 1'b0;
                    phase_q = '0;
                end
            end
            OP_ENCODER:
            begin
                step_val = step_amount(step_q);
                next_speed = (a ^ b) ? longint'(speed_q) + step_val
                                     : longint'(speed_q) - step_val;
                if (next_speed <= 1) next_speed = 10;
                if (next_speed > longint'(SPEED_MAX)) next_speed = longint'(SPEED_MAX);
                speed_q = SPEED_BITS'(next_speed);
                on_time_q = ON_TIME_BITS'(longint'(MINUTE_US) / next_speed);
            end
            OP_BUTTON:
            begin
                if (!btn && hold_q < CNT_MAX) hold_q = hold_q + 1'b1;
                if (hold_q >= hold_limit_cfg)
                begin
                    speed_q = SPEED_FORCED;
                    hold_q = '0;
                end
                else if (hold_q != '0 && btn)
                begin
                    pressed = 1'b1;
                    hold_q = '0;
                end
                if (pressed && lockout_q >= lockout_cfg)
                begin
                    step_q = (step_q == STEP_LAST) ? STEP_FIRST : step_q + 1'b1;
                    lockout_q = '0;
                end
            end
            default: ;
        endcase
        w.led_on      = led_q;
        w.speed_value = speed_q;
        w.step_select = step_q;
        w.on_time_us  = on_time_q;
        w.press_event = pressed;
    endtask

    task automatic check_field(input string field, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s: expected %0d, actual %0d", field, want_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        strobe_word_t want;
        strobe_word_t got;
        if (!rst_n)
        begin
            hold_limit_cfg = HOLD_LIMIT_RST;
            lockout_cfg    = LOCKOUT_RST;
            ratio_cfg      = RATIO_RST;
            speed_q        = '0;
            step_q         = STEP_RST;
            on_time_q      = '0;
            led_q          = 1'b0;
            phase_q        = '0;
            hold_q         = '0;
            lockout_q      = '0;
            strobe_words.delete();
            mismatches = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready) apply_register(cfg.index, cfg.data);
            if (item.valid && item.ready)
            begin
                predict_word(item.operation, item.encoder_a, item.encoder_b,
                             item.button_level, want);
                strobe_words.push_back(want);
            end
            if (result.valid && result.ready)
            begin
                got.led_on      = result.led_on;
                got.speed_value = result.speed_value;
                got.step_select = result.step_select;
                got.on_time_us  = result.on_time_us;
                got.press_event = result.press_event;
                if (strobe_words.size() == 0)
                begin
                    $error("result word with no word expected");
                    mismatches++;
                end
                else
                begin
                    want = strobe_words.pop_front();
                    check_field("led_on", 32'(want.led_on), 32'(got.led_on));
                    check_field("speed_value", 32'(want.speed_value), 32'(got.speed_value));
                    check_field("step_select", 32'(want.step_select), 32'(got.step_select));
                    check_field("on_time_us", 32'(want.on_time_us), 32'(got.on_time_us));
                    check_field("press_event", 32'(want.press_event), 32'(got.press_event));
                end
            end
            fail_count <= mismatches;
            pending    <= strobe_words.size();
        end
    end

endmodule

// ----- bench/tb_strobe_rate_controller_core.sv -----
// Testbench top: drives ticks, encoder edges, button samples, idle codes and config writes into the strobe controller.
`timescale 1ns / 1ps

module tb_strobe_rate_controller_core;
    import src_pkg::*;

    localparam int LONG_HOLD_CYCLES = 300;
    localparam int CLIMB_EDGES      = 400;
    localparam int PHASE_ITEMS      = 300;
    localparam int TAIL_CYCLES      = 40;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_words;
    bit   idle_on;
    bit   long_hold_req;
    int   sender_quiet;

    src_in_if  item();
    src_out_if result();
    src_cfg_if cfg();

    strobe_rate_controller_core uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result),
        .cfg    (cfg)
    );

    strobe_rate_checker rate_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .result     (result),
        .cfg        (cfg),
        .fail_count (fail_count),
        .pending    (pending_words)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

    task automatic send_word(input logic [OP_BITS-1:0] op, input logic a, input logic b,
                             input logic btn);
        if (idle_on)
        begin
            if (sender_quiet > 0)
                sender_quiet--;
            else if ($urandom_range(0, 31) == 0)
                sender_quiet = $urandom_range(50, 150);
            else if ($urandom_range(0, 7) == 0)
            begin
                item.valid <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
        end
        item.valid        <= 1'b1;
        item.operation    <= op;
        item.encoder_a    <= a;
        item.encoder_b    <= b;
        item.button_level <= btn;
        @(posedge clk);
        while (!item.ready) @(posedge clk);
    endtask

    task automatic drain_results();
        item.valid <= 1'b0;
        @(posedge clk);
        while (pending_words != 0) @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
    endtask

    task automatic load_settings(input logic [CNT_BITS-1:0] hold_v,
                                 input logic [CNT_BITS-1:0] lock_v,
                                 input logic [RATIO_BITS-1:0] ratio_v);
        drain_results();
        put_reg(CFG_HOLD_LIMIT, hold_v);
        put_reg(CFG_LOCKOUT, lock_v);
        put_reg(CFG_RATIO, CFG_DATA_BITS'(ratio_v));
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic climb(input int edges);
        logic a;
        repeat (edges)
        begin
            a = 1'($urandom_range(0, 1));
            send_word(OP_ENCODER, a, ~a, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic run_random(input int quota, input int hold_span);
        int               sent;
        int               n;
        int               kind;
        logic             a;
        logic [OP_BITS-1:0] op;
        sent = 0;
        while (sent < quota)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 45)
            begin
                n = $urandom_range(1, 30);
                repeat (n) send_word(OP_TICK, 1'($urandom_range(0, 1)),
                                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                sent += n;
            end
            else if (kind < 65)
            begin
                n = $urandom_range(1, hold_span);
                repeat (n) send_word(OP_BUTTON, 1'($urandom_range(0, 1)),
                                     1'($urandom_range(0, 1)), 1'b0);
                send_word(OP_BUTTON, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          1'b1);
                sent += n + 1;
            end
            else if (kind < 85)
            begin
                n = $urandom_range(1, 4);
                repeat (n)
                begin
                    a = 1'($urandom_range(0, 1));
                    send_word(OP_ENCODER, a, ($urandom_range(0, 9) < 6) ? ~a : a,
                              1'($urandom_range(0, 1)));
                end
                sent += n;
            end
            else if (kind < 90)
            begin
                n = $urandom_range(10, 40);
                climb(n);
                sent += n;
            end
            else if (kind < 97)
            begin
                op = OP_BITS'($urandom_range(0, 3));
                send_word(op, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
                if (op != 2'd3) sent++;
            end
            else
                drain_results();
        end
    endtask

    initial
    begin : drive_result_ready
        int stall_left;
        int free_left;
        stall_left = 0;
        free_left  = 0;
        result.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                stall_left = LONG_HOLD_CYCLES;
            end
            else if (idle_on && stall_left == 0 && free_left == 0)
            begin
                if ($urandom_range(0, 3) == 0)
                    stall_left = $urandom_range(1, 15);
                else
                    free_left = ($urandom_range(0, 15) == 0) ? $urandom_range(50, 150)
                                                              : $urandom_range(1, 12);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result.ready <= 1'b0;
            end
            else
            begin
                if (free_left > 0) free_left--;
                result.ready <= 1'b1;
            end
        end
    end

    initial
    begin : stimulus
        int hold_v;
        idle_on       = 1'b1;
        long_hold_req = 1'b0;
        sender_quiet  = 0;
        rst_n             <= 1'b0;
        item.valid        <= 1'b0;
        item.operation    <= OP_TICK;
        item.encoder_a    <= 1'b0;
        item.encoder_b    <= 1'b0;
        item.button_level <= 1'b1;
        cfg.valid         <= 1'b0;
        cfg.index         <= CFG_HOLD_LIMIT;
        cfg.data          <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // power-up settings: zero on time, step of 50, release inside lockout
        repeat (3) send_word(OP_TICK, 1'b0, 1'b0, 1'b1);
        send_word(2'd3, 1'b1, 1'b1, 1'b1);
        send_word(OP_ENCODER, 1'b0, 1'b0, 1'b0);
        send_word(OP_ENCODER, 1'b1, 1'b0, 1'b0);
        send_word(OP_ENCODER, 1'b0, 1'b1, 1'b1);
        send_word(OP_ENCODER, 1'b1, 1'b1, 1'b0);
        send_word(OP_BUTTON, 1'b0, 1'b0, 1'b0);
        send_word(OP_BUTTON, 1'b1, 1'b1, 1'b1);
        send_word(OP_BUTTON, 1'b0, 1'b1, 1'b1);

        // step wraps, hold forcing, underflow from one rpm
        load_settings(20'd3, 20'd0, 4'd15);
        repeat (3)
        begin
            send_word(OP_BUTTON, 1'b0, 1'b0, 1'b0);
            send_word(OP_BUTTON, 1'b0, 1'b0, 1'b1);
        end
        repeat (3) send_word(OP_BUTTON, 1'b1, 1'b0, 1'b0);
        send_word(OP_BUTTON, 1'b0, 1'b1, 1'b1);
        send_word(OP_ENCODER, 1'b0, 1'b0, 1'b1);
        repeat (4)
        begin
            send_word(OP_BUTTON, 1'b0, 1'b0, 1'b0);
            send_word(OP_BUTTON, 1'b1, 1'b1, 1'b1);
        end

        // hold limit zero, ratio zero
        load_settings(20'd0, 20'd0, 4'd0);
        send_word(OP_BUTTON, 1'b0, 1'b0, 1'b1);
        send_word(OP_BUTTON, 1'b1, 1'b1, 1'b0);
        repeat (2) send_word(OP_TICK, 1'b1, 1'b0, 1'b0);

        // climb with the largest step
        load_settings(CNT_MAX, CNT_MAX, 4'd1);
        climb(CLIMB_EDGES);

        load_settings(20'd5, 20'd20, 4'd1);
        long_hold_req = 1'b1;
        run_random(PHASE_ITEMS / 2, 6);
        drain_results();
        run_random(PHASE_ITEMS - PHASE_ITEMS / 2, 6);

        load_settings(CNT_MAX, CNT_MAX, 4'd15);
        run_random(PHASE_ITEMS, 16);

        load_settings(20'd1, 20'd0, 4'd0);
        run_random(PHASE_ITEMS, 3);

        hold_v = $urandom_range(2, 12);
        load_settings(CNT_BITS'(hold_v), CNT_BITS'($urandom_range(0, 200)),
                      RATIO_BITS'($urandom_range(1, 15)));
        run_random(PHASE_ITEMS, hold_v + 1);

        idle_on = 1'b0;
        hold_v = $urandom_range(2, 12);
        load_settings(CNT_BITS'(hold_v), CNT_BITS'($urandom_range(0, 200)),
                      RATIO_BITS'($urandom_range(1, 15)));
        run_random(PHASE_ITEMS, hold_v + 1);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
